/* src/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// lfu_pkg
// shared types and constants of the lfu cache table: item formats, table
// entry layout, controller commands and datapath status
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int USE_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int STAMP_W     = 32;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [CAP_W-1:0]   t_cap;
    typedef logic [USE_W-1:0]   t_use;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [STAMP_W-1:0] t_stamp;

    localparam logic                     OP_GET     = 1'b0;
    localparam logic                     OP_PUT     = 1'b1;
    localparam t_cap                     CAP_RESET  = 5'd16;
    localparam t_count                   COUNT_MAX  = '1;
    localparam t_count                   COUNT_ONE  = 16'd1;
    localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] lookup_key;
        logic signed [DATA_W-1:0] store_value;
    } t_in_item;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
    } t_out_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
        t_count                   use_count;
        t_stamp                   stamp;
    } t_entry;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

/* src/lfu_cache_table.sv */
// items: one in flight; a new item is taken only after the last one's result is
//   committed to the output register; the scan reads one table entry per cycle
//   through the single read port
// reset: synchronous active low; empties the table, zeroes the stamp counter and
//   sets the capacity to 16; no clearing pass is needed
// ----------------------------------------------------------------------------
// lfu_cache_table
// key-value cache with least-frequently-used replacement, oldest stamp
// breaking ties between equal use counts
// ----------------------------------------------------------------------------
module lfu_cache_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lfu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lfu_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  lfu_pkg::t_cap      i_cfg_wdata
);

    lfu_pkg::t_cmd cmd;
    lfu_pkg::t_sts sts;

    lfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lfu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

endmodule

/* src/lfu_ctrl.sv */
// ----------------------------------------------------------------------------
// lfu_ctrl
// sequencer of the lfu cache table: takes an item, runs the table scan and
// commits the update once the output register can take the result
// ----------------------------------------------------------------------------
module lfu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lfu_pkg::t_sts i_sts,
    output lfu_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   accept;

    assign accept     = i_in_valid && !r_in_stall;
    assign o_in_stall = r_in_stall;

    always_comb begin
        o_cmd.start  = accept;
        o_cmd.scan   = (r_state == ST_SCAN);
        o_cmd.commit = (r_state == ST_FINISH) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_in_stall <= 1'b1;
            end else if (o_cmd.commit) begin
                r_in_stall <= 1'b0;
            end
        end
    end

endmodule

/* src/lfu_dpath.sv */
// ----------------------------------------------------------------------------
// lfu_dpath
// entry table, scan trackers for key match, victim and free slot, stamp
// counter, capacity register and the output register
// ----------------------------------------------------------------------------
module lfu_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lfu_pkg::t_cmd      i_cmd,
    output lfu_pkg::t_sts      o_sts,
    input  lfu_pkg::t_in_item  i_in_item,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output lfu_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  lfu_pkg::t_cap      i_cfg_wdata
);

    lfu_pkg::t_entry           r_mem [lfu_pkg::MAX_ENTRIES];
    logic [lfu_pkg::MAX_ENTRIES-1:0] r_valid;

    lfu_pkg::t_cap             r_cap;
    lfu_pkg::t_stamp           r_stamp_ctr;
    lfu_pkg::t_in_item         r_item;

    lfu_pkg::t_cnt             r_addr;
    logic                      r_rd_vld;
    lfu_pkg::t_idx             r_rd_idx;
    lfu_pkg::t_entry           r_rd_entry;

    logic                      r_hit;
    lfu_pkg::t_idx             r_hit_slot;
    logic signed [lfu_pkg::DATA_W-1:0] r_hit_value;
    lfu_pkg::t_count           r_hit_count;
    logic                      r_vic_found;
    lfu_pkg::t_idx             r_vic_slot;
    lfu_pkg::t_count           r_vic_count;
    lfu_pkg::t_stamp           r_vic_stamp;
    logic                      r_free_found;
    lfu_pkg::t_idx             r_free_slot;
    lfu_pkg::t_cnt             r_used;

    logic                      r_out_valid;
    lfu_pkg::t_out_item        r_out_item;

    logic                      rd_issue;
    logic                      rd_live;
    logic                      key_match;
    logic                      vic_better;
    logic                      is_put;
    logic                      full;
    logic                      evict;
    logic                      wr_en;
    lfu_pkg::t_idx             wr_slot;
    lfu_pkg::t_entry           wr_entry;
    lfu_pkg::t_out_item        res;

    assign rd_issue  = i_cmd.scan && (r_addr != lfu_pkg::t_cnt'(lfu_pkg::MAX_ENTRIES));
    assign rd_live   = r_rd_vld && r_valid[r_rd_idx];
    assign key_match = (r_rd_entry.key == r_item.lookup_key);
    assign vic_better = !r_vic_found
        || (r_rd_entry.use_count < r_vic_count)
        || ((r_rd_entry.use_count == r_vic_count) && (r_rd_entry.stamp < r_vic_stamp));

    always_comb begin
        o_sts.scan_done = (r_addr == lfu_pkg::t_cnt'(lfu_pkg::MAX_ENTRIES)) && !r_rd_vld;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    // occupancy at or above the capacity, capacity above the table size saturates
    assign is_put = (r_item.opcode == lfu_pkg::OP_PUT);
    assign full   = (lfu_pkg::t_use'(r_used) >= lfu_pkg::t_use'(r_cap))
        || (r_used == lfu_pkg::t_cnt'(lfu_pkg::MAX_ENTRIES));
    assign evict  = is_put && (r_cap != '0) && !r_hit && full && r_vic_found;

    always_comb begin
        wr_en = 1'b0;
        if (!is_put) begin
            wr_en = r_hit;
        end else if (r_cap != '0) begin
            wr_en = r_hit || evict || r_free_found;
        end
        wr_en = wr_en && i_cmd.commit;

        if (r_hit) begin
            wr_slot = r_hit_slot;
        end else if (evict) begin
            wr_slot = r_vic_slot;
        end else begin
            wr_slot = r_free_slot;
        end

        wr_entry.key   = r_item.lookup_key;
        wr_entry.value = is_put ? r_item.store_value : r_hit_value;
        wr_entry.stamp = r_stamp_ctr;
        if (!r_hit) begin
            wr_entry.use_count = lfu_pkg::COUNT_ONE;
        end else if (r_hit_count == lfu_pkg::COUNT_MAX) begin
            wr_entry.use_count = r_hit_count;
        end else begin
            wr_entry.use_count = r_hit_count + lfu_pkg::COUNT_ONE;
        end

        res.hit        = r_hit;
        res.read_value = (!is_put && r_hit) ? r_hit_value : lfu_pkg::MISS_VALUE;
        res.evicted    = evict;
    end

    // entry table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_slot] <= wr_entry;
        end
        if (rd_issue) begin
            r_rd_entry <= r_mem[r_addr[lfu_pkg::IDX_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_cap        <= lfu_pkg::CAP_RESET;
            r_stamp_ctr  <= '0;
            r_addr       <= '0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_vic_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (wr_en) begin
                r_valid[wr_slot] <= 1'b1;
                r_stamp_ctr      <= r_stamp_ctr + lfu_pkg::t_stamp'(1);
            end
            r_rd_vld <= rd_issue;
            if (i_cmd.start) begin
                r_addr       <= '0;
                r_hit        <= 1'b0;
                r_vic_found  <= 1'b0;
                r_free_found <= 1'b0;
                r_used       <= '0;
            end else begin
                if (rd_issue) begin
                    r_addr <= r_addr + lfu_pkg::t_cnt'(1);
                end
                if (rd_live) begin
                    r_used <= r_used + lfu_pkg::t_cnt'(1);
                    if (key_match && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (vic_better) begin
                        r_vic_found <= 1'b1;
                    end
                end else if (r_rd_vld && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_item <= i_in_item;
        end
        if (rd_issue) begin
            r_rd_idx <= r_addr[lfu_pkg::IDX_W-1:0];
        end
        if (rd_live) begin
            if (key_match && !r_hit) begin
                r_hit_slot  <= r_rd_idx;
                r_hit_value <= r_rd_entry.value;
                r_hit_count <= r_rd_entry.use_count;
            end
            if (vic_better) begin
                r_vic_slot  <= r_rd_idx;
                r_vic_count <= r_rd_entry.use_count;
                r_vic_stamp <= r_rd_entry.stamp;
            end
        end else if (r_rd_vld && !r_free_found) begin
            r_free_slot <= r_rd_idx;
        end
        if (i_cmd.commit) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* src/lfu_checker.sv */
// ----------------------------------------------------------------------------
// lfu_checker
// port-level checks of the lfu cache table, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_stall,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input lfu_pkg::t_out_item i_out_item
);

    // one item in flight at a time
    `ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)
    // an eviction only happens on a miss
    `ASSERT_IMP(a_evict_on_miss, i_clk, i_rst_n, i_out_valid && i_out_item.evicted,
        !i_out_item.hit)
    // a miss never returns stored data
    `ASSERT_IMP(a_miss_value, i_clk, i_rst_n, i_out_valid && !i_out_item.hit,
        i_out_item.read_value == lfu_pkg::MISS_VALUE)
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)
    `ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(i_out_item))

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
